### src/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  // Line and group geometry
  localparam int GROUPS_PER_LINE = 19;
  localparam int GOL_W           = 5;

  // Characters one input byte can produce, and the count width
  localparam int MAX_CHARS = 5;
  localparam int CNT_W     = 3;

  // Entries in the queue between the classify and emit parts
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Special characters
  localparam logic [6:0] PAD_CHAR  = 7'h3D;
  localparam logic [6:0] NL_CHAR   = 7'h0A;
  localparam logic [6:0] PLUS_CHAR = 7'h2B;
  localparam logic [6:0] SLSH_CHAR = 7'h2F;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_item_t;

  // One classified byte: the characters it causes, in order
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } entry_t;

  // Map a sextet to its alphabet character
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      r = PLUS_CHAR;
    end else begin
      r = SLSH_CHAR;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/b64e_front.sv
`default_nettype none

module b64e_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire b64e_pkg::in_item_t in_data,
  input  wire                  fifo_full,
  input  wire                  cfg_valid,
  input  wire                  cfg_wdata,
  output logic                 full,
  output logic                 fifo_push,
  output b64e_pkg::entry_t     fifo_wdata
);

  logic [1:0]                 gpos_r,  gpos_nxt;
  logic [3:0]                 left_r,  left_nxt;
  logic [b64e_pkg::GOL_W-1:0] gol_r,   gol_nxt;
  logic                       wrap_r;
  logic                       accept;
  logic [b64e_pkg::GOL_W-1:0] gol_inc;
  logic                       line_done;
  logic [7:0]                 b;
  logic                       lst;

  assign full      = fifo_full;
  assign accept    = push && !fifo_full;
  assign fifo_push = accept;
  assign b         = in_data.data_byte;
  assign lst       = in_data.last_byte;
  assign gol_inc   = gol_r + 1'b1;
  assign line_done = (gol_inc >= b64e_pkg::GOL_W'(b64e_pkg::GROUPS_PER_LINE));

  // Classify the byte by its place in the group and build its characters
  always_comb begin
    fifo_wdata       = '0;
    fifo_wdata.last  = lst;
    gpos_nxt         = gpos_r;
    left_nxt         = left_r;
    gol_nxt          = gol_r;
    case (gpos_r)
      2'd0: begin
        fifo_wdata.chars[0] = b64e_pkg::b64_char(b[7:2]);
        fifo_wdata.count    = 3'd1;
        left_nxt            = {2'b00, b[1:0]};
        gpos_nxt            = 2'd1;
        if (lst) begin
          fifo_wdata.chars[1] = b64e_pkg::b64_char({b[1:0], 4'b0000});
          fifo_wdata.chars[2] = b64e_pkg::PAD_CHAR;
          fifo_wdata.chars[3] = b64e_pkg::PAD_CHAR;
          fifo_wdata.chars[4] = b64e_pkg::NL_CHAR;
          fifo_wdata.count    = wrap_r ? 3'd5 : 3'd4;
        end
      end
      2'd1: begin
        fifo_wdata.chars[0] = b64e_pkg::b64_char({left_r[1:0], b[7:4]});
        fifo_wdata.count    = 3'd1;
        left_nxt            = b[3:0];
        gpos_nxt            = 2'd2;
        if (lst) begin
          fifo_wdata.chars[1] = b64e_pkg::b64_char({b[3:0], 2'b00});
          fifo_wdata.chars[2] = b64e_pkg::PAD_CHAR;
          fifo_wdata.chars[3] = b64e_pkg::NL_CHAR;
          fifo_wdata.count    = wrap_r ? 3'd4 : 3'd3;
        end
      end
      default: begin
        fifo_wdata.chars[0] = b64e_pkg::b64_char({left_r, b[7:6]});
        fifo_wdata.chars[1] = b64e_pkg::b64_char(b[5:0]);
        fifo_wdata.chars[2] = b64e_pkg::NL_CHAR;
        fifo_wdata.count    = (wrap_r && (line_done || lst)) ? 3'd3 : 3'd2;
        left_nxt            = 4'd0;
        gpos_nxt            = 2'd0;
        gol_nxt             = line_done ? '0 : gol_inc;
      end
    endcase
    // Drop all group state at end of message
    if (lst) begin
      gpos_nxt = 2'd0;
      left_nxt = 4'd0;
      gol_nxt  = '0;
    end
  end

  // Advance group state on each accepted transaction; take wrap setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpos_r <= 2'd0;
      left_r <= 4'd0;
      gol_r  <= '0;
      wrap_r <= 1'b0;
    end else begin
      if (accept) begin
        gpos_r <= gpos_nxt;
        left_r <= left_nxt;
        gol_r  <= gol_nxt;
      end
      if (cfg_valid) begin
        wrap_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

### src/b64e_fifo.sv
`default_nettype none

module b64e_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  wire b64e_pkg::entry_t wr_data,
  input  wire              rd_en,
  output b64e_pkg::entry_t rd_data,
  output logic             fifo_full,
  output logic             fifo_empty
);

  b64e_pkg::entry_t             mem_r [b64e_pkg::FIFO_DEPTH];
  logic [b64e_pkg::PTR_W-1:0]   wr_ptr_r;
  logic [b64e_pkg::PTR_W-1:0]   rd_ptr_r;
  logic [b64e_pkg::PTR_W:0]     count_r, count_nxt;

  assign fifo_full  = (count_r == (b64e_pkg::PTR_W+1)'(b64e_pkg::FIFO_DEPTH));
  assign fifo_empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### src/b64e_back.sv
`default_nettype none

module b64e_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire b64e_pkg::entry_t head,
  input  wire                  fifo_empty,
  output logic                 fifo_pop,
  input  wire                  pop,
  output logic                 empty,
  output b64e_pkg::out_item_t  out_data
);

  logic [b64e_pkg::CNT_W-1:0] idx_r;
  logic                       oval_r;
  b64e_pkg::out_item_t        odata_r;
  logic                       load;
  logic                       final_char;

  assign empty      = !oval_r;
  assign out_data   = odata_r;
  assign load       = !fifo_empty && (!oval_r || pop);
  assign final_char = (idx_r == head.count - 1'b1);
  assign fifo_pop   = load && final_char;

  // Step through the head entry, one character per cycle while the receiver takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      if (load) begin
        oval_r <= 1'b1;
        idx_r  <= final_char ? '0 : idx_r + 1'b1;
      end else if (pop) begin
        oval_r <= 1'b0;
      end
    end
  end

  // Hold the output character until taken
  always_ff @(posedge clk) begin
    if (load) begin
      odata_r.out_char  <= head.chars[idx_r];
      odata_r.last_char <= head.last && final_char;
    end
  end

endmodule

`default_nettype wire

### src/base64_stream_encoder.sv
// Base64 stream encoder with optional 76-character line wrapping.
// Input channel: one byte per transaction with a last-byte flag; a
//   transaction completes when push is high and full is low.
// Result channel: one ASCII character per transaction; the oldest character
//   is on out_data while empty is low and leaves when pop is high.
// Config channel: cfg_wdata sets the wrap enable, written when cfg_valid
//   and cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Path: an accepted byte is written into the queue, and its characters then
//   move one by one from the queue head into the output register.
// Throughput: a byte can be accepted every cycle while the four-entry queue
//   has room; characters leave at one per cycle while the receiver pops, so
//   one byte yields 1 to 5 characters, about 1.33 on average.
// Reset clears group state and the queue, empties the output register and sets
//   wrapping off. When the receiver stalls, the output holds, the queue
//   fills and full rises; no transaction is lost.
`default_nettype none

module base64_stream_encoder (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire b64e_pkg::in_item_t in_data,
  output logic                 full,
  output logic                 empty,
  input  wire                  pop,
  output b64e_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_wdata
);

  logic             fifo_full;
  logic             fifo_empty;
  logic             fifo_push;
  logic             fifo_pop;
  b64e_pkg::entry_t fifo_wdata;
  b64e_pkg::entry_t fifo_rdata;

  assign cfg_ready = 1'b1;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .fifo_full  (fifo_full),
    .cfg_valid  (cfg_valid),
    .cfg_wdata  (cfg_wdata),
    .full       (full),
    .fifo_push  (fifo_push),
    .fifo_wdata (fifo_wdata)
  );

  b64e_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (fifo_push),
    .wr_data    (fifo_wdata),
    .rd_en      (fifo_pop),
    .rd_data    (fifo_rdata),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (fifo_rdata),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

### src/b64e_checker.sv
`default_nettype none

module b64e_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  full,
  input wire                  empty,
  input wire                  pop,
  input wire b64e_pkg::out_item_t out_data
);

  // Reset leaves no result waiting and the input open
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input blocked after reset");

  // A full queue always has a character presented
  a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue full while output empty");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire

### tb/base64_stream_encoder_test.sv
// Expected Base64 text for the encoder, one character per result transaction
class b64_char_scoreboard;
  localparam logic [6:0] PAD     = 7'h3D;
  localparam logic [6:0] NEWLINE = 7'h0A;

  bit                      wrap_on;
  logic [1:0]              byte_slot;
  logic [3:0]              carry_bits;
  logic [4:0]              line_groups;
  b64e_pkg::out_item_t     expected_chars[$];
  int                      errors;
  string                   alphabet;

  function new();
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    wrap_on = 1'b0;
    byte_slot = '0;
    carry_bits = '0;
    line_groups = '0;
    errors = 0;
  endfunction

  function void set_wrap(bit v);
    wrap_on = v;
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  function void add_char(logic [6:0] c);
    b64e_pkg::out_item_t e;
    e.out_char = c;
    e.last_char = 1'b0;
    expected_chars.push_back(e);
  endfunction

  function void add_sextet(logic [5:0] v);
    byte c;
    c = alphabet[int'(v)];
    add_char(c[6:0]);
  endfunction

  // Predict the characters that one accepted byte releases
  function void note_byte(b64e_pkg::in_item_t item);
    logic [7:0]          b;
    bit                  line_broken;
    b64e_pkg::out_item_t e;
    b = item.data_byte;
    line_broken = 1'b0;
    case (byte_slot)
      2'd0: begin
        add_sextet(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        byte_slot = 2'd1;
        if (item.last_byte) begin
          add_sextet({carry_bits[1:0], 4'b0000});
          add_char(PAD);
          add_char(PAD);
          if (wrap_on) add_char(NEWLINE);
        end
      end
      2'd1: begin
        add_sextet({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        byte_slot = 2'd2;
        if (item.last_byte) begin
          add_sextet({carry_bits, 2'b00});
          add_char(PAD);
          if (wrap_on) add_char(NEWLINE);
        end
      end
      default: begin
        add_sextet({carry_bits, b[7:6]});
        add_sextet(b[5:0]);
        carry_bits = '0;
        byte_slot = 2'd0;
        line_groups = line_groups + 5'd1;
        // After a full set of groups restart the count; only wrapping adds the newline
        if (line_groups >= b64e_pkg::GROUPS_PER_LINE) begin
          line_groups = '0;
          if (wrap_on) begin
            add_char(NEWLINE);
            line_broken = 1'b1;
          end
        end
        if (item.last_byte && wrap_on && !line_broken) add_char(NEWLINE);
      end
    endcase
    // Flag the final character and start the next message clean
    if (item.last_byte) begin
      e = expected_chars.pop_back();
      e.last_char = 1'b1;
      expected_chars.push_back(e);
      byte_slot = '0;
      carry_bits = '0;
      line_groups = '0;
    end
  endfunction

  function void check_char(b64e_pkg::out_item_t got);
    b64e_pkg::out_item_t e;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected character: expected none, got char %h last %b",
               $time, got.out_char, got.last_char);
      errors++;
    end else begin
      e = expected_chars.pop_front();
      if (got.out_char !== e.out_char) begin
        $display("%0t: out_char mismatch: expected %h, got %h",
                 $time, e.out_char, got.out_char);
        errors++;
      end
      if (got.last_char !== e.last_char) begin
        $display("%0t: last_char mismatch: expected %b, got %b",
                 $time, e.last_char, got.last_char);
        errors++;
      end
    end
  endfunction
endclass

module base64_stream_encoder_test;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 8;

  logic                clk;
  logic                rst_n;
  logic                push;
  b64e_pkg::in_item_t  in_data;
  logic                full;
  logic                empty;
  logic                pop;
  b64e_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_wdata;

  int          send_idle_pct = 15;
  int          recv_idle_pct = 49;
  int unsigned cycles = 0;
  bit          wrap_now;
  b64_char_scoreboard sb;

  base64_stream_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch every handshake at the edge and feed the scoreboard
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_wrap(cfg_wdata);
      if (push && !full) sb.note_byte(in_data);
      if (pop && !empty) sb.check_char(out_data);
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    b64e_pkg::in_item_t item;
    item.data_byte = b;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Hold the input and wait until every predicted character has left
  task automatic drain_chars();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_wrap(input bit v);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    wrap_now = v;
  endtask

  // Send one message of random bytes, sometimes flipping wrap partway through
  task automatic send_message(input int len);
    int split_at;
    split_at = ($urandom_range(4) == 0 && len > 1) ? $urandom_range(len - 1, 1) : 0;
    for (int i = 0; i < len; i++) begin
      if (split_at != 0 && i == split_at) begin
        drain_chars();
        write_wrap(!wrap_now);
      end
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit wrap_v,
                           input int budget);
    int sent;
    int len;
    drain_chars();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_wrap(wrap_v);
    // Start with exactly one full line so the line break lands on the last byte
    send_message(57);
    sent = 57;
    while (sent < budget) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(64, 50) : $urandom_range(9, 1);
      send_message(len);
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    push <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_wdata <= 1'b0;
    wrap_now = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-, two- and three-byte messages with wrapping on
    write_wrap(1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // Turn wrapping off in the middle of a group
    send_byte(8'h4D, 1'b0);
    drain_chars();
    write_wrap(1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h7F, 1'b1);

    // Turn wrapping off just before a group completes on the last byte
    drain_chars();
    write_wrap(1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    drain_chars();
    write_wrap(1'b0);
    send_byte(8'h56, 1'b1);

    // Random messages under each idling profile
    run_phase(15, 49, 1'b1, 60);
    run_phase(49, 15, 1'b0, 60);
    run_phase(0, 0, 1'($urandom_range(1)), 60);

    drain_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_fifo.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
src/b64e_checker.sv
tb/base64_stream_encoder_test.sv
